>>> rtl/ttl_pkg.sv
// Shared types and constants for the thrust tilt limiter.
`default_nettype none
package ttl_pkg;

	localparam int unsigned REG_W  = 23;
	localparam int unsigned VEC_W  = 24;
	localparam int unsigned RAD_W  = 48;
	localparam int unsigned ROOT_W = 24;
	localparam int unsigned SQR_W  = 28;

	typedef enum logic [1:0] {
		CFG_THR_CAP   = 2'd0,
		CFG_THR_BASE  = 2'd1,
		CFG_TAN_TILT  = 2'd2
	} ttl_cfg_e;

	// queue entry between front and back
	typedef struct packed {
		logic [REG_W-1:0] tilt;
		logic [RAD_W-1:0] rad;
		logic [RAD_W-1:0] sum;
		logic [VEC_W-1:0] ax;
		logic [VEC_W-1:0] ay;
		logic             nx;
		logic             ny;
		logic [REG_W-1:0] zc;
	} ttl_job_t;

	// carried alongside the root pipeline
	typedef struct packed {
		logic [REG_W-1:0] tilt;
		logic [RAD_W-1:0] sum;
		logic [VEC_W-1:0] ax;
		logic [VEC_W-1:0] ay;
		logic             nx;
		logic             ny;
		logic [REG_W-1:0] zc;
	} ttl_sq_side_t;

	// carried alongside the divider pipeline
	typedef struct packed {
		logic             exceed;
		logic [VEC_W-1:0] ax;
		logic [VEC_W-1:0] ay;
		logic             nx;
		logic             ny;
		logic [REG_W-1:0] zc;
	} ttl_dv_side_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SQR_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} ttl_sq_lane_t;

	typedef struct packed {
		logic [VEC_W-1:0] rem;
		logic [VEC_W-1:0] num;
		logic [VEC_W-1:0] quo;
	} ttl_dv_lane_t;

endpackage
`default_nettype wire

>>> rtl/ttl_fifo.sv
// Short job queue between the front and back halves.
`default_nettype none
module ttl_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ttl_pkg::ttl_job_t wdata,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output ttl_pkg::ttl_job_t      rdata
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ttl_pkg::ttl_job_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/ttl_front.sv
// Front half: vertical clamp, magnitudes, products and radicands.
`default_nettype none
module ttl_front #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] want_x,
	input  wire logic signed [23:0] want_y,
	input  wire logic signed [23:0] want_z,
	input  wire logic [22:0]        thr_cap,
	input  wire logic [22:0]        thr_base,
	input  wire logic [22:0]        tan_max_tilt,
	input  wire logic               q_full,
	output logic                    q_push,
	output ttl_pkg::ttl_job_t       q_job
);
	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [24:0] z_ext, z_hi, z_lo;
	logic [23:0] ax_d, ay_d;

	logic [22:0] zc_s1;
	logic [23:0] ax_s1, ay_s1;
	logic        nx_s1, ny_s1;

	logic [45:0] tz_s2, tm2_s2, z2_s2;
	logic [47:0] xx_s2, yy_s2;
	logic [22:0] zc_s2;
	logic [23:0] ax_s2, ay_s2;
	logic        nx_s2, ny_s2;

	logic [45:0] tilt_w;
	ttl_pkg::ttl_job_t job_s3;

	assign en       = !v_s3 || !q_full;
	assign in_stall = !en;
	assign q_push   = v_s3 && !q_full;
	assign q_job    = job_s3;

	always_comb begin
		z_ext = {want_z[23], want_z};
		z_hi  = (z_ext > $signed({2'b00, thr_cap})) ? $signed({2'b00, thr_cap}) : z_ext;
		z_lo  = (z_hi < $signed({2'b00, thr_base})) ? $signed({2'b00, thr_base}) : z_hi;
		ax_d  = want_x[23] ? 24'(-want_x) : 24'(want_x);
		ay_d  = want_y[23] ? 24'(-want_y) : 24'(want_y);
		tilt_w = tz_s2 >> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s1 <= z_lo[22:0];
			ax_s1 <= ax_d;
			ay_s1 <= ay_d;
			nx_s1 <= want_x[23];
			ny_s1 <= want_y[23];

			tz_s2  <= zc_s1 * tan_max_tilt;
			tm2_s2 <= thr_cap * thr_cap;
			z2_s2  <= zc_s1 * zc_s1;
			xx_s2  <= ax_s1 * ax_s1;
			yy_s2  <= ay_s1 * ay_s1;
			zc_s2  <= zc_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;

			job_s3.tilt <= (|tilt_w[45:23]) ? '1 : tilt_w[22:0];
			job_s3.rad  <= (tm2_s2 > z2_s2) ? {2'b00, tm2_s2 - z2_s2} : '0;
			job_s3.sum  <= xx_s2 + yy_s2;
			job_s3.ax   <= ax_s2;
			job_s3.ay   <= ay_s2;
			job_s3.nx   <= nx_s2;
			job_s3.ny   <= ny_s2;
			job_s3.zc   <= zc_s2;
		end
	end
endmodule
`default_nettype wire

>>> rtl/ttl_isqrt.sv
// Two-lane pipelined integer square root, one root bit per stage.
`default_nettype none
module ttl_isqrt #(
	parameter int unsigned SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [47:0]   rad_a,
	input  wire logic [47:0]   rad_b,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [23:0]        root_a,
	output logic [23:0]        root_b,
	output logic [SW-1:0]      side_out
);
	localparam int unsigned N = ttl_pkg::ROOT_W;

	function automatic ttl_pkg::ttl_sq_lane_t step(input ttl_pkg::ttl_sq_lane_t l);
		ttl_pkg::ttl_sq_lane_t o;
		logic [ttl_pkg::SQR_W-1:0] r2, t;
		r2 = {l.rem[ttl_pkg::SQR_W-3:0], l.rad[47:46]};
		t  = {2'b00, l.root, 2'b01};
		o.rad = {l.rad[45:0], 2'b00};
		if (r2 >= t) begin
			o.rem  = r2 - t;
			o.root = {l.root[N-2:0], 1'b1};
		end else begin
			o.rem  = r2;
			o.root = {l.root[N-2:0], 1'b0};
		end
		return o;
	endfunction

	ttl_pkg::ttl_sq_lane_t a_d [0:N];
	ttl_pkg::ttl_sq_lane_t b_d [0:N];
	logic [SW-1:0]         sd_d [0:N];
	logic                  v_d  [0:N];

	assign a_d[0]  = '{rad: rad_a, rem: '0, root: '0};
	assign b_d[0]  = '{rad: rad_b, rem: '0, root: '0};
	assign sd_d[0] = side_in;
	assign v_d[0]  = in_valid;

	for (genvar i = 0; i < N; i++) begin : g_stage
		ttl_pkg::ttl_sq_lane_t a_q, b_q;
		logic [SW-1:0]         sd_q;
		logic                  v_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= v_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_q  <= step(a_d[i]);
				b_q  <= step(b_d[i]);
				sd_q <= sd_d[i];
			end
		end

		assign a_d[i+1]  = a_q;
		assign b_d[i+1]  = b_q;
		assign sd_d[i+1] = sd_q;
		assign v_d[i+1]  = v_q;
	end

	assign out_valid = v_d[N];
	assign root_a    = a_d[N].root;
	assign root_b    = b_d[N].root;
	assign side_out  = sd_d[N];
endmodule
`default_nettype wire

>>> rtl/ttl_div.sv
// Two-lane pipelined restoring divider sharing one divisor.
`default_nettype none
module ttl_div #(
	parameter int unsigned SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [47:0]   num_a,
	input  wire logic [47:0]   num_b,
	input  wire logic [23:0]   den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [23:0]        quo_a,
	output logic [23:0]        quo_b,
	output logic [SW-1:0]      side_out
);
	localparam int unsigned N = ttl_pkg::VEC_W;

	function automatic ttl_pkg::ttl_dv_lane_t step(input ttl_pkg::ttl_dv_lane_t l,
			input logic [N-1:0] d);
		ttl_pkg::ttl_dv_lane_t o;
		logic [N:0] r2;
		r2 = {l.rem, l.num[N-1]};
		o.num = {l.num[N-2:0], 1'b0};
		if (r2 >= {1'b0, d}) begin
			o.rem = N'(r2 - {1'b0, d});
			o.quo = {l.quo[N-2:0], 1'b1};
		end else begin
			o.rem = r2[N-1:0];
			o.quo = {l.quo[N-2:0], 1'b0};
		end
		return o;
	endfunction

	ttl_pkg::ttl_dv_lane_t a_d [0:N];
	ttl_pkg::ttl_dv_lane_t b_d [0:N];
	logic [N-1:0]          dn_d [0:N];
	logic [SW-1:0]         sd_d [0:N];
	logic                  v_d  [0:N];

	assign a_d[0]  = '{rem: num_a[47:24], num: num_a[23:0], quo: '0};
	assign b_d[0]  = '{rem: num_b[47:24], num: num_b[23:0], quo: '0};
	assign dn_d[0] = den;
	assign sd_d[0] = side_in;
	assign v_d[0]  = in_valid;

	for (genvar i = 0; i < N; i++) begin : g_stage
		ttl_pkg::ttl_dv_lane_t a_q, b_q;
		logic [N-1:0]          dn_q;
		logic [SW-1:0]         sd_q;
		logic                  v_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= v_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_q  <= step(a_d[i], dn_d[i]);
				b_q  <= step(b_d[i], dn_d[i]);
				dn_q <= dn_d[i];
				sd_q <= sd_d[i];
			end
		end

		assign a_d[i+1]  = a_q;
		assign b_d[i+1]  = b_q;
		assign dn_d[i+1] = dn_q;
		assign sd_d[i+1] = sd_q;
		assign v_d[i+1]  = v_q;
	end

	assign out_valid = v_d[N];
	assign quo_a     = a_d[N].quo;
	assign quo_b     = b_d[N].quo;
	assign side_out  = sd_d[N];
endmodule
`default_nettype wire

>>> rtl/ttl_back.sv
// Back half: roots, limit select, exceed test, scaling and output register.
`default_nettype none
module ttl_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire ttl_pkg::ttl_job_t  q_job,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      lim_x,
	output logic signed [23:0]      lim_y,
	output logic [22:0]             lim_z
);
	localparam int unsigned SQ_SW = $bits(ttl_pkg::ttl_sq_side_t);
	localparam int unsigned DV_SW = $bits(ttl_pkg::ttl_dv_side_t);

	logic en;
	logic out_valid_q;

	ttl_pkg::ttl_sq_side_t sq_in, sq_out;
	logic        sq_valid;
	logic [23:0] root_rad, root_sum;

	logic        v_s1, v_s2, v_s3;
	logic [22:0] h_s1;
	logic [23:0] mag_s1, mag_s2, mag_s3;
	ttl_pkg::ttl_sq_side_t sd_s1, sd_s2, sd_s3;
	logic [45:0] hh_s2;
	logic [46:0] px_s2, py_s2, px_s3, py_s3;
	logic        exc_s3;

	ttl_pkg::ttl_dv_side_t dv_in, dv_out;
	logic        dv_valid;
	logic [23:0] qx, qy, ox, oy;

	assign en        = !out_valid_q || !out_stall;
	assign q_pop     = en && q_valid;
	assign out_valid = out_valid_q;

	assign sq_in = '{tilt: q_job.tilt, sum: q_job.sum, ax: q_job.ax, ay: q_job.ay,
		nx: q_job.nx, ny: q_job.ny, zc: q_job.zc};

	ttl_isqrt #(.SW(SQ_SW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (q_valid),
		.rad_a    (q_job.rad),
		.rad_b    (q_job.sum),
		.side_in  (sq_in),
		.out_valid(sq_valid),
		.root_a   (root_rad),
		.root_b   (root_sum),
		.side_out (sq_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= sq_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= (sq_out.tilt < root_rad[22:0]) ? sq_out.tilt : root_rad[22:0];
			mag_s1 <= (root_sum == '0) ? 24'd1 : root_sum;
			sd_s1  <= sq_out;

			hh_s2  <= h_s1 * h_s1;
			px_s2  <= sd_s1.ax * h_s1;
			py_s2  <= sd_s1.ay * h_s1;
			mag_s2 <= mag_s1;
			sd_s2  <= sd_s1;

			exc_s3 <= (sd_s2.sum > {2'b00, hh_s2});
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			mag_s3 <= mag_s2;
			sd_s3  <= sd_s2;
		end
	end

	assign dv_in = '{exceed: exc_s3, ax: sd_s3.ax, ay: sd_s3.ay,
		nx: sd_s3.nx, ny: sd_s3.ny, zc: sd_s3.zc};

	ttl_div #(.SW(DV_SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num_a    ({1'b0, px_s3}),
		.num_b    ({1'b0, py_s3}),
		.den      (mag_s3),
		.side_in  (dv_in),
		.out_valid(dv_valid),
		.quo_a    (qx),
		.quo_b    (qy),
		.side_out (dv_out)
	);

	always_comb begin
		ox = dv_out.exceed ? qx : dv_out.ax;
		oy = dv_out.exceed ? qy : dv_out.ay;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lim_x <= dv_out.nx ? $signed(24'(-ox)) : $signed(ox);
			lim_y <= dv_out.ny ? $signed(24'(-oy)) : $signed(oy);
			lim_z <= dv_out.zc;
		end
	end
endmodule
`default_nettype wire

>>> rtl/thrust_tilt_limiter.sv
// Thrust tilt limiter: clamps a desired thrust vector by vertical range and tilt.
// Input channel in_valid/in_stall carries want_x, want_y, want_z (signed Q8.16).
// Output channel out_valid/out_stall carries lim_x, lim_y (signed) and lim_z.
// Configuration: cfg_we with cfg_idx 0 thrust cap, 1 thrust floor, 2 tan_max_tilt;
// cfg_data bits 22:0 are taken, other indexes are ignored. Write only while idle.
// Throughput: one vector per cycle while the receiver does not stall.
// Path from input beat to output beat: 3 front stages, the queue, 24 square
// root stages, 3 limit stages, 24 divider stages and the output register.
// The root and divider pipelines make up most of this path.
// A 4-entry queue sits between the front and back pipelines. When the receiver
// stalls, the back pipeline holds; the front keeps filling the queue and
// raises in_stall only when the queue is full and its last stage is occupied.
// Reset clears all valid flags and loads a thrust cap of 1.0, a thrust floor
// of 0 and tan_max_tilt 37837 (about 30 degrees).
`default_nettype none
module thrust_tilt_limiter #(
	parameter int unsigned FRAC_BITS   = 16,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] want_x,
	input  wire logic signed [23:0] want_y,
	input  wire logic signed [23:0] want_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      lim_x,
	output logic signed [23:0]      lim_y,
	output logic [22:0]             lim_z
);
	logic [22:0] thr_cap_q, thr_base_q, tan_max_tilt_q;

	logic              q_push, q_full, q_pop, q_valid;
	ttl_pkg::ttl_job_t q_wjob, q_rjob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_cap_q      <= 23'd65536;
			thr_base_q     <= 23'd0;
			tan_max_tilt_q <= 23'd37837;
		end else if (cfg_we) begin
			unique case (ttl_pkg::ttl_cfg_e'(cfg_idx))
				ttl_pkg::CFG_THR_CAP:  thr_cap_q      <= cfg_data;
				ttl_pkg::CFG_THR_BASE: thr_base_q     <= cfg_data;
				ttl_pkg::CFG_TAN_TILT: tan_max_tilt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ttl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.want_x      (want_x),
		.want_y      (want_y),
		.want_z      (want_z),
		.thr_cap     (thr_cap_q),
		.thr_base    (thr_base_q),
		.tan_max_tilt(tan_max_tilt_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_wjob)
	);

	ttl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wjob),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rjob)
	);

	ttl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_rjob),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lim_x    (lim_x),
		.lim_y    (lim_y),
		.lim_z    (lim_z)
	);
endmodule
`default_nettype wire

>>> test/ttl_checker.sv
// Checker for the thrust tilt limiter: predicts each result and compares output beats.
module ttl_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [23:0] want_x,
	input  wire logic signed [23:0] want_y,
	input  wire logic signed [23:0] want_z,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [23:0] lim_x,
	input  wire logic signed [23:0] lim_y,
	input  wire logic [22:0]        lim_z,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [22:0]        z;
	} limited_vec_t;

	logic [22:0] thr_cap_r, thr_base_r, tan_tilt_r;
	limited_vec_t limited_q[$];

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic limited_vec_t limit_vector(logic signed [23:0] wx, logic signed [23:0] wy,
			logic signed [23:0] wz);
		longint z, x, y;
		longint unsigned zc, tilt, tot, h, ax, ay, s, mag, tm2, z2, ox, oy;
		limited_vec_t r;
		x = wx;
		y = wy;
		z = wz;
		if (z > longint'(thr_cap_r))
			z = thr_cap_r;
		if (z < longint'(thr_base_r))
			z = thr_base_r;
		zc = z;
		tilt = (zc * tan_tilt_r) >> 16;
		tm2 = longint'(thr_cap_r) * longint'(thr_cap_r);
		z2 = zc * zc;
		tot = (tm2 > z2) ? isqrt(tm2 - z2) : 0;
		h = (tilt < tot) ? tilt : tot;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		s = ax * ax + ay * ay;
		ox = ax;
		oy = ay;
		if (s > h * h) begin
			mag = isqrt(s);
			if (mag == 0)
				mag = 1;
			ox = (ax * h) / mag;
			oy = (ay * h) / mag;
		end
		r.x = (x < 0) ? 24'(-ox) : 24'(ox);
		r.y = (y < 0) ? 24'(-oy) : 24'(oy);
		r.z = 23'(zc);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		limited_vec_t e;
		if (!arst_n) begin
			thr_cap_r  <= 23'd65536;
			thr_base_r <= 23'd0;
			tan_tilt_r <= 23'd37837;
			errors     = 0;
			limited_q.delete();
		end else begin
			if (in_valid && !in_stall)
				limited_q.push_back(limit_vector(want_x, want_y, want_z));
			if (out_valid && !out_stall) begin
				if (limited_q.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					e = limited_q.pop_front();
					if (lim_x !== e.x) report_mismatch("lim_x", lim_x, e.x);
					if (lim_y !== e.y) report_mismatch("lim_y", lim_y, e.y);
					if (lim_z !== e.z) report_mismatch("lim_z", lim_z, e.z);
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					ttl_pkg::CFG_THR_CAP:  thr_cap_r  <= cfg_data;
					ttl_pkg::CFG_THR_BASE: thr_base_r <= cfg_data;
					ttl_pkg::CFG_TAN_TILT: tan_tilt_r <= cfg_data;
					default: ;
				endcase
			end
		end
		pending = limited_q.size();
	end
endmodule

>>> test/testbench.sv
// Top of the thrust tilt limiter testbench: stimulus, configuration phases and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = 0;
	logic [22:0] cfg_data = 0;
	logic in_valid = 0, out_stall = 0;
	logic signed [23:0] want_x = 0, want_y = 0, want_z = 0;
	wire in_stall, out_valid;
	wire signed [23:0] lim_x, lim_y;
	wire [22:0] lim_z;
	int errors, pending, cycles = 0;
	bit quiet = 0, hold_off = 0;

	always #1 clk = ~clk;

	thrust_tilt_limiter dut (.*);
	ttl_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stalls in bursts; a long hold-off when asked
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic write_reg(ttl_pkg::ttl_cfg_e idx, logic [22:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic send_vec(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		want_x <= x;
		want_y <= y;
		want_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic [23:0] rand_comp(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 262144)) - 131072);
			default: return 24'($signed($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	initial begin
		logic [23:0] ext[6];
		int mode;
		ext = '{24'h800000, 24'h7FFFFF, 24'h0, 24'h1, 24'hFFFFFF, 24'h010000};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes under reset settings
		foreach (ext[i])
			send_vec(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
		send_vec(24'h00C000, 24'hFF4000, 24'h000000);
		send_vec(24'h001000, 24'h000800, 24'h008000);
		in_valid <= 0;
		drain();
		// minimum above maximum; vertical above total limit
		write_reg(ttl_pkg::CFG_THR_CAP, 23'd40000);
		write_reg(ttl_pkg::CFG_THR_BASE, 23'd50000);
		write_reg(ttl_pkg::CFG_TAN_TILT, 23'h7FFFFF);
		send_vec(24'h010000, 24'hFF0000, 24'h000100);
		send_vec(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		in_valid <= 0;
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(ttl_pkg::CFG_THR_CAP, 23'h7FFFFF);
					write_reg(ttl_pkg::CFG_THR_BASE, 0);
					write_reg(ttl_pkg::CFG_TAN_TILT, 23'h7FFFFF); end
				1: begin write_reg(ttl_pkg::CFG_THR_CAP, 0);
					write_reg(ttl_pkg::CFG_TAN_TILT, 0); end
				default: begin
					write_reg(ttl_pkg::CFG_THR_CAP, 23'($urandom_range(0, 200000)));
					write_reg(ttl_pkg::CFG_THR_BASE, 23'($urandom_range(0, 70000)));
					write_reg(ttl_pkg::CFG_TAN_TILT, 23'($urandom_range(0, 200000)));
				end
			endcase
			if (ph == 2)
				hold_off = 1;
			if (ph == 5)
				quiet = 1;
			for (int k = 0; k < 320; k++) begin
				mode = $urandom_range(0, 2);
				send_vec(rand_comp(mode), rand_comp(mode), rand_comp($urandom_range(0, 2)));
			end
			in_valid <= 0;
			drain();
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> sim.f
rtl/ttl_pkg.sv
rtl/ttl_fifo.sv
rtl/ttl_front.sv
rtl/ttl_isqrt.sv
rtl/ttl_div.sv
rtl/ttl_back.sv
rtl/thrust_tilt_limiter.sv
test/ttl_checker.sv
test/testbench.sv
